// File: rtl/adcfir_pkg.sv
// Shared constants, coefficient table and coefficient rounding for the ADC scaler and FIR.
`timescale 1ns / 1ps
`default_nettype none

package adcfir_pkg;

    localparam int CODE_W     = 12;
    localparam int SAMPLE_W   = 23;
    localparam int OUT_W      = 26;
    localparam int TABLE_TAPS = 32;
    localparam int GROUP_SIZE = 8;

    localparam int TAP_COUNT_DEF      = 32;
    localparam int COEF_FRAC_BITS_DEF = 17;

    // code * 100 * 2^16 / 4095 == m + m / 4095 with m = code * 1600
    localparam int SCALE_MUL = 1600;
    localparam int SCALE_DEN = 4095;
    localparam int SPLIT_W   = 12;

    localparam longint COEF_UNIT = 100000000;

    // low-pass taps in units of 1e-8
    localparam int LP_COEF_E8 [TABLE_TAPS] = '{
        -63047, -181857, -256194, -158749, 236951, 833250, 1180361, 675930,
        -917451, -2973091, -3981645, -2230165, 3102797, 11114350, 19245540, 24373020,
        24373020, 19245540, 11114350, 3102797, -2230165, -3981645, -2973091, -917451,
        675930, 1180361, 833250, 236951, -158749, -256194, -181857, -63047
    };

    // round half away from zero to Q1.frac; taps past the table are zero
    function automatic longint tap_coef(input int k, input int frac);
        longint c;
        longint mag;
        longint q;
        if (k < 0 || k >= TABLE_TAPS) begin
            return 0;
        end
        c   = longint'(LP_COEF_E8[k]);
        mag = (c < 0) ? -c : c;
        q   = ((mag << frac) + COEF_UNIT / 2) / COEF_UNIT;
        return (c < 0) ? -q : q;
    endfunction

endpackage

`default_nettype wire

// File: rtl/adcfir_scale.sv
// Input register and code-to-Q7.16 scaling.
`timescale 1ns / 1ps
`default_nettype none

module adcfir_scale (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [adcfir_pkg::CODE_W-1:0]     in_code,
    input  wire logic                              in_start,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [adcfir_pkg::SAMPLE_W-1:0]        out_sample,
    output logic                                   out_start
);

    localparam int SW = adcfir_pkg::SAMPLE_W;
    localparam int HW = SW - adcfir_pkg::SPLIT_W;
    localparam int AW = adcfir_pkg::SPLIT_W + 1;

    logic                             valid_reg;
    logic [adcfir_pkg::CODE_W-1:0]    code_reg;
    logic                             start_reg;

    logic [SW-1:0]                    prod_m;
    logic [HW-1:0]                    hi_part;
    logic [adcfir_pkg::SPLIT_W-1:0]   lo_part;
    logic [AW-1:0]                    hi_lo_sum;
    logic                             wrap;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            code_reg  <= in_code;
            start_reg <= in_start;
        end
    end

    // m = a * 4096 + b, so m / 4095 = a + (a + b >= 4095)
    always_comb begin
        prod_m    = SW'(code_reg) * SW'(adcfir_pkg::SCALE_MUL);
        hi_part   = prod_m[SW-1:adcfir_pkg::SPLIT_W];
        lo_part   = prod_m[adcfir_pkg::SPLIT_W-1:0];
        hi_lo_sum = AW'(hi_part) + AW'(lo_part);
        wrap      = (hi_lo_sum >= AW'(adcfir_pkg::SCALE_DEN));
        out_sample = prod_m + SW'(hi_part) + SW'(wrap);
    end

    assign out_valid = valid_reg;
    assign out_start = start_reg;

endmodule

`default_nettype wire

// File: rtl/adcfir_taps.sv
// Delay line register with frame clear, and registered per-tap products.
`timescale 1ns / 1ps
`default_nettype none

module adcfir_taps #(
    parameter int TAP_COUNT      = adcfir_pkg::TAP_COUNT_DEF,
    parameter int COEF_FRAC_BITS = adcfir_pkg::COEF_FRAC_BITS_DEF,
    parameter int PROD_W         = adcfir_pkg::SAMPLE_W + COEF_FRAC_BITS + 2
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [adcfir_pkg::SAMPLE_W-1:0]   in_sample,
    input  wire logic                              in_start,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [PROD_W-1:0]               out_prod [TAP_COUNT]
);

    localparam int SW = adcfir_pkg::SAMPLE_W;

    logic [SW-1:0]              tap_reg [TAP_COUNT];
    logic                       tap_valid_reg;
    logic signed [PROD_W-1:0]   prod_reg  [TAP_COUNT];
    logic signed [PROD_W-1:0]   prod_next [TAP_COUNT];
    logic                       prod_valid_reg;
    logic                       prod_ready;

    assign prod_ready = !prod_valid_reg || out_ready;
    assign in_ready   = !tap_valid_reg || prod_ready;

    // newest sample in tap 0; frame start zeroes the older taps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_valid_reg <= 1'b0;
            for (int k = 0; k < TAP_COUNT; k++) begin
                tap_reg[k] <= '0;
            end
        end else begin
            if (in_valid && in_ready) begin
                tap_valid_reg <= 1'b1;
                tap_reg[0]    <= in_sample;
                for (int k = 1; k < TAP_COUNT; k++) begin
                    tap_reg[k] <= in_start ? '0 : tap_reg[k-1];
                end
            end else if (prod_ready) begin
                tap_valid_reg <= 1'b0;
            end
        end
    end

    for (genvar k = 0; k < TAP_COUNT; k++) begin : g_tap
        localparam logic signed [PROD_W-1:0] COEF =
            PROD_W'(adcfir_pkg::tap_coef(k, COEF_FRAC_BITS));
        logic signed [PROD_W-1:0] sample_ext;
        always_comb begin
            sample_ext   = $signed(PROD_W'(tap_reg[k]));
            prod_next[k] = sample_ext * COEF;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (prod_ready) begin
            prod_valid_reg <= tap_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_ready && tap_valid_reg) begin
            for (int k = 0; k < TAP_COUNT; k++) begin
                prod_reg[k] <= prod_next[k];
            end
        end
    end

    assign out_valid = prod_valid_reg;
    assign out_prod  = prod_reg;

endmodule

`default_nettype wire

// File: rtl/adcfir_sum.sv
// Two-level registered adder tree, floor shift to Q9.16 and output register.
`timescale 1ns / 1ps
`default_nettype none

module adcfir_sum #(
    parameter int TAP_COUNT      = adcfir_pkg::TAP_COUNT_DEF,
    parameter int COEF_FRAC_BITS = adcfir_pkg::COEF_FRAC_BITS_DEF,
    parameter int PROD_W         = adcfir_pkg::SAMPLE_W + COEF_FRAC_BITS + 2
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [PROD_W-1:0]          in_prod [TAP_COUNT],
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [adcfir_pkg::OUT_W-1:0]           out_data
);

    localparam int GS         = adcfir_pkg::GROUP_SIZE;
    localparam int NUM_GROUPS = (TAP_COUNT + GS - 1) / GS;
    localparam int PAD_TAPS   = NUM_GROUPS * GS;
    localparam int ACC_W      = PROD_W + $clog2(TAP_COUNT);

    logic signed [ACC_W-1:0]   prod_pad  [PAD_TAPS];
    logic signed [ACC_W-1:0]   group_next [NUM_GROUPS];
    logic signed [ACC_W-1:0]   group_reg  [NUM_GROUPS];
    logic                      group_valid_reg;
    logic signed [ACC_W-1:0]   total;
    logic signed [ACC_W-1:0]   shifted;
    logic [adcfir_pkg::OUT_W-1:0] out_data_reg;
    logic                      out_valid_reg;
    logic                      out_adv;

    assign out_adv  = !out_valid_reg || out_ready;
    assign in_ready = !group_valid_reg || out_adv;

    for (genvar i = 0; i < PAD_TAPS; i++) begin : g_pad
        if (i < TAP_COUNT) begin : g_used
            assign prod_pad[i] = ACC_W'(in_prod[i]);
        end else begin : g_zero
            assign prod_pad[i] = '0;
        end
    end

    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            group_next[g] = '0;
            for (int j = 0; j < GS; j++) begin
                group_next[g] = group_next[g] + prod_pad[g*GS + j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_valid_reg <= 1'b0;
        end else if (in_ready) begin
            group_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                group_reg[g] <= group_next[g];
            end
        end
    end

    // arithmetic shift gives the floor
    always_comb begin
        total = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            total = total + group_reg[g];
        end
        shifted = total >>> COEF_FRAC_BITS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= group_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && group_valid_reg) begin
            out_data_reg <= shifted[adcfir_pkg::OUT_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// File: rtl/adc_scale_fir_lowpass_32tap_top.sv
// Top level: ADC code scaler feeding a symmetric low-pass FIR, stream in and out.
//
//  channel  dir  tdata (low bit up)                     tuser
//  s_       in   [11:0] adc_code, [15:12] zero          [0] frame_start
//  m_       out  [25:0] filtered_sample, [31:26] zero   -
//
// One item per cycle sustained while m_tready holds; each item passes the
// input reg, tap reg, products, group sums and output reg in turn.
// aresetn is synchronous, active low, and zeroes the delay line.
// Each stage holds its item on a stall and takes a new one whenever it
// is empty or moving on, so bubbles collapse and input keeps flowing
// while a result waits at the output, until all five stages hold an item.
`timescale 1ns / 1ps
`default_nettype none

module adc_scale_fir_lowpass_32tap_top #(
    parameter int TAP_COUNT      = adcfir_pkg::TAP_COUNT_DEF,
    parameter int COEF_FRAC_BITS = adcfir_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [15:0]  s_tdata,   // [11:0] adc_code
    input  wire logic         s_tuser,   // [0] frame_start
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [31:0]       m_tdata    // [25:0] filtered_sample
);

    localparam int PROD_W = adcfir_pkg::SAMPLE_W + COEF_FRAC_BITS + 2;

    logic                                  sc_valid;
    logic                                  sc_ready;
    logic [adcfir_pkg::SAMPLE_W-1:0]       sc_sample;
    logic                                  sc_start;
    logic                                  tp_valid;
    logic                                  tp_ready;
    logic signed [PROD_W-1:0]              tp_prod [TAP_COUNT];
    logic [adcfir_pkg::OUT_W-1:0]          sum_data;

    adcfir_scale u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_code    (s_tdata[adcfir_pkg::CODE_W-1:0]),
        .in_start   (s_tuser),
        .out_valid  (sc_valid),
        .out_ready  (sc_ready),
        .out_sample (sc_sample),
        .out_start  (sc_start)
    );

    adcfir_taps #(
        .TAP_COUNT      (TAP_COUNT),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .PROD_W         (PROD_W)
    ) u_taps (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sc_valid),
        .in_ready  (sc_ready),
        .in_sample (sc_sample),
        .in_start  (sc_start),
        .out_valid (tp_valid),
        .out_ready (tp_ready),
        .out_prod  (tp_prod)
    );

    adcfir_sum #(
        .TAP_COUNT      (TAP_COUNT),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .PROD_W         (PROD_W)
    ) u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (tp_valid),
        .in_ready  (tp_ready),
        .in_prod   (tp_prod),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (sum_data)
    );

    assign m_tdata = {{(32 - adcfir_pkg::OUT_W){1'b0}}, sum_data};

endmodule

`default_nettype wire
